// ===== rtl/fqks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fqks_pkg;

  // Port widths fixed by the interface
  localparam int KEY_PORT_W = 64;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int POS_W      = 5;
  localparam int SERVED_W   = 16;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 64;

  localparam logic [SERVED_W-1:0] SERVED_MAX = '1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;
  localparam logic [OP_W-1:0] OP_READ = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [KEY_PORT_W-1:0] head_key;
    logic [POS_W-1:0]      position;
    logic [SERVED_W-1:0]   served_count;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/fqks_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key store: one write port, one read port, registered read data.
module fqks_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fqks_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: pointers, occupancy, served counter, scan over the key store.
module fqks_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_BITS    = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire logic [fqks_pkg::OP_W-1:0]          in_opcode,
  input  wire logic [fqks_pkg::KEY_PORT_W-1:0]    in_key,
  output      logic                               res_valid,
  input  wire logic                               res_ready,
  output      fqks_pkg::res_t                     res,
  output      logic                               mem_we,
  output      logic [$clog2(QUEUE_DEPTH)-1:0]     mem_waddr,
  output      logic [KEY_BITS-1:0]                mem_wdata,
  output      logic                               mem_re,
  output      logic [$clog2(QUEUE_DEPTH)-1:0]     mem_raddr,
  input  wire logic [KEY_BITS-1:0]                mem_rdata
);

  import fqks_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [1:0]          state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [SERVED_W-1:0] served_r, served_nxt;
  logic [OW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       scan_r, scan_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [KEY_PORT_W-1:0] hkey_r, hkey_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  logic [KEY_BITS-1:0] in_key_m;
  logic [OW-1:0]       k_inc;

  assign in_key_m = in_key[KEY_BITS-1:0];
  assign k_inc    = k_r + 1'b1;

  assign res.status       = status_r;
  assign res.head_key     = hkey_r;
  assign res.position     = pos_r;
  assign res.served_count = served_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    occ_nxt    = occ_r;
    served_nxt = served_r;
    k_nxt      = k_r;
    scan_nxt   = scan_r;
    key_nxt    = key_r;
    status_nxt = status_r;
    hkey_nxt   = hkey_r;
    pos_nxt    = pos_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = tail_r;
    mem_wdata  = in_key_m;
    mem_re     = 1'b0;
    mem_raddr  = head_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = ST_OK;
          hkey_nxt   = '0;
          pos_nxt    = '0;
          state_nxt  = S_DONE;
          unique case (in_opcode)
            OP_ENQ: begin
              if (occ_r == OW'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                tail_nxt = next_slot(tail_r);
                occ_nxt  = occ_r + 1'b1;
              end
            end
            OP_DEQ: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_DEQ;
              end
            end
            OP_FIND: begin
              if (occ_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                scan_nxt  = head_r;
                k_nxt     = '0;
                key_nxt   = in_key_m;
                state_nxt = S_SCAN;
              end
            end
            OP_READ: begin
              status_nxt = ST_OK;
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_DEQ: begin
        hkey_nxt  = KEY_PORT_W'(mem_rdata);
        head_nxt  = next_slot(head_r);
        occ_nxt   = occ_r - 1'b1;
        if (served_r != SERVED_MAX) begin
          served_nxt = served_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // mem_rdata holds the entry at scan_r, k_r places behind the head
        if (mem_rdata == key_r) begin
          status_nxt = ST_OK;
          pos_nxt    = POS_W'(k_inc);
          state_nxt  = S_DONE;
        end else if (k_inc == occ_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = k_inc;
          scan_nxt  = next_slot(scan_r);
          mem_re    = 1'b1;
          mem_raddr = next_slot(scan_r);
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      served_r <= '0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      served_r <= served_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    scan_r   <= scan_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    hkey_r   <= hkey_nxt;
    pos_r    <= pos_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/fifo_queue_with_key_search.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bounded FIFO of keys with key search. Each input transfer carries an
// opcode and a key and yields exactly one result transfer: enqueue stores
// the key at the tail (status full if no room), dequeue returns the head
// key (status empty if none, not counted), find returns the 1-based
// position of the first entry equal to the key counted from the head
// (status empty or not found, position zero), and read returns the
// saturating count of served dequeues, which is also on every result.
// Only the low KEY_BITS bits of a key are stored and compared. Keys live
// in a single-port-read synchronous memory, so one item is in work at a
// time: find makes one memory read per entry examined, from the head up to
// the match or through the whole occupancy when nothing matches (at most
// QUEUE_DEPTH reads). Results sit in an output register, so the next input
// is taken while a result waits. No clearing pass after reset; the store
// is only read at occupied slots.
module fifo_queue_with_key_search #(
  parameter int QUEUE_DEPTH = fqks_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = fqks_pkg::DEF_KEY_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic [fqks_pkg::OP_W-1:0]        in_opcode,
  input  wire logic [fqks_pkg::KEY_PORT_W-1:0]  in_key,
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [fqks_pkg::STATUS_W-1:0]    out_status,
  output      logic [fqks_pkg::KEY_PORT_W-1:0]  out_head_key,
  output      logic [fqks_pkg::POS_W-1:0]       out_position,
  output      logic [fqks_pkg::SERVED_W-1:0]    out_served_count
);

  import fqks_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic                res_valid;
  logic                res_ready;
  res_t                res;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [KEY_BITS-1:0] mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [KEY_BITS-1:0] mem_rdata;

  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  fqks_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fqks_mem #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_head_key     = out_r.head_key;
  assign out_position     = out_r.position;
  assign out_served_count = out_r.served_count;

endmodule

`default_nettype wire
